[sv/drld_pkg.sv]
// shared constants, codes and types of the dictionary run-length decoder
package drld_pkg;

    // dictionary geometry
    localparam int TABLES     = 4;
    localparam int ENTRIES    = 256;
    localparam int COUNT_BITS = 16;
    localparam int TBL_W      = $clog2(TABLES);
    localparam int ENT_W      = $clog2(ENTRIES);
    localparam int RAM_AW     = TBL_W + ENT_W;
    localparam int RAM_DEPTH  = TABLES * ENTRIES;
    localparam int RAM_W      = COUNT_BITS + 8;
    localparam int CMP_W      = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    // queue sizes
    localparam int MID_DEPTH = 4;
    localparam int MID_AW    = $clog2(MID_DEPTH);
    localparam int OUT_DEPTH = 2;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);

    // item operation codes
    typedef logic [1:0] t_op;
    localparam t_op OP_DATA  = 2'd0;
    localparam t_op OP_FRAME = 2'd1;
    localparam t_op OP_DICT  = 2'd2;

    // register indexes and reset values
    typedef logic t_reg_idx;
    localparam t_reg_idx REG_FRAME_BYTES = 1'b0;
    localparam t_reg_idx REG_DICT_COUNT  = 1'b1;
    localparam logic [15:0] FRAME_BYTES_RST = 16'd8192;
    localparam logic [2:0]  DICT_COUNT_RST  = 3'd4;

    // length byte that continues a literal count
    localparam logic [7:0] LEN_ESCAPE = 8'd255;

    // decoder phase
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_COUNT = 4'b0010,
        PH_LIT   = 4'b0100,
        PH_CODE  = 4'b1000
    } t_phase;

    // item handed from front to back, with its dictionary entry
    typedef struct packed {
        t_op                   op;
        logic [7:0]            data_byte;
        logic [2:0]            dict_number;
        logic [COUNT_BITS-1:0] tbl_count;
        logic [7:0]            tbl_value;
    } t_mid_item;

    // one result run
    typedef struct packed {
        logic [7:0]  run_value;
        logic [15:0] repeat_count;
        logic        frame_done;
        logic        overrun;
    } t_run;

endpackage

[sv/drld_ram.sv]
// generic simple dual-port ram with registered read
module drld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

[sv/drld_front.sv]
// front end: accepts items, owns the dictionary memory, queues items for the back end
module drld_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [1:0]          i_op,
    input  logic [7:0]          i_data_byte,
    input  logic [2:0]          i_dict_number,
    input  logic [7:0]          i_entry_index,
    input  logic [15:0]         i_entry_count,
    input  logic [7:0]          i_entry_value,
    output logic                o_mid_valid,
    output drld_pkg::t_mid_item o_mid,
    input  logic                i_mid_pop
);
    import drld_pkg::*;

    logic                accept;
    logic                wr_en;
    logic [RAM_AW-1:0]   wr_addr;
    logic [RAM_W-1:0]    wr_data;
    logic [RAM_AW-1:0]   rd_addr;
    logic [RAM_W-1:0]    rd_data;
    t_mid_item           mid_push_item;

    logic                r_s1_valid;
    t_op                 r_s1_op;
    logic [7:0]          r_s1_byte;
    logic [2:0]          r_s1_dnum;
    logic [TBL_W-1:0]    r_active_table;

    t_mid_item           r_mid_q [MID_DEPTH];
    logic [MID_AW-1:0]   r_wr_ptr;
    logic [MID_AW-1:0]   r_rd_ptr;
    logic [MID_AW:0]     r_mid_cnt;
    logic [MID_AW:0]     n_mid_cnt;

    // credit check: queue entries plus the item in the read stage
    assign o_full = (({1'b0, r_mid_cnt} + (MID_AW+2)'(r_s1_valid))
                     >= (MID_AW+2)'(MID_DEPTH));
    assign accept = i_push && !o_full;

    // dictionary writes land at accept, code lookups read at accept
    assign wr_en   = accept && (i_op == OP_DICT) && ({1'b0, i_dict_number} < 4'(TABLES));
    assign wr_addr = {i_dict_number[TBL_W-1:0], i_entry_index};
    assign wr_data = {i_entry_value, COUNT_BITS'(i_entry_count)};
    assign rd_addr = {r_active_table, i_data_byte};

    drld_ram #(
        .WIDTH (RAM_W),
        .DEPTH (RAM_DEPTH)
    ) u_tables (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // read stage control and active table tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_active_table <= '0;
        end else begin
            r_s1_valid <= accept;
            if (accept && (i_op == OP_FRAME)) begin
                r_active_table <= i_dict_number[TBL_W-1:0];
            end
        end
    end

    // read stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op   <= i_op;
            r_s1_byte <= i_data_byte;
            r_s1_dnum <= i_dict_number;
        end
    end

    // item with its table entry joins the queue
    always_comb begin
        mid_push_item.op          = r_s1_op;
        mid_push_item.data_byte   = r_s1_byte;
        mid_push_item.dict_number = r_s1_dnum;
        mid_push_item.tbl_count   = rd_data[COUNT_BITS-1:0];
        mid_push_item.tbl_value   = rd_data[RAM_W-1 -: 8];
    end

    // queue occupancy
    always_comb begin
        n_mid_cnt = r_mid_cnt + (MID_AW+1)'(r_s1_valid) - (MID_AW+1)'(i_mid_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_mid_cnt <= '0;
        end else begin
            r_mid_cnt <= n_mid_cnt;
            if (r_s1_valid) begin
                r_wr_ptr <= r_wr_ptr + MID_AW'(1);
            end
            if (i_mid_pop) begin
                r_rd_ptr <= r_rd_ptr + MID_AW'(1);
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_mid_q[r_wr_ptr] <= mid_push_item;
        end
    end

    assign o_mid_valid = (r_mid_cnt != '0);
    assign o_mid       = r_mid_q[r_rd_ptr];
endmodule

[sv/drld_back.sv]
// back end: frame decoding state machine and result queue
module drld_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [15:0]         i_frame_bytes,
    input  logic [2:0]          i_dict_count,
    input  logic                i_mid_valid,
    input  drld_pkg::t_mid_item i_mid,
    output logic                o_mid_pop,
    output logic                o_empty,
    input  logic                i_pop,
    output drld_pkg::t_run      o_run
);
    import drld_pkg::*;

    t_phase            r_phase, n_phase;
    logic              r_raw, n_raw;
    logic [15:0]       r_len_sum, n_len_sum;
    logic [15:0]       r_lit_left, n_lit_left;
    logic [15:0]       r_emitted, n_emitted;

    t_run              r_out_q [OUT_DEPTH];
    logic [OUT_AW-1:0] r_out_wr, r_out_rd;
    logic [OUT_AW:0]   r_out_cnt;

    logic              go;
    logic              res_valid;
    t_run              res;
    logic              out_pop;
    logic [16:0]       left_diff;
    logic [15:0]       left;
    logic [16:0]       sum_raw;
    logic [15:0]       sum_sat;
    logic [15:0]       lit_dec;
    logic [CMP_W-1:0]  cnt_w;
    logic [CMP_W-1:0]  left_w;

    // take an item when a result slot is free
    assign go        = i_mid_valid && (r_out_cnt != (OUT_AW+1)'(OUT_DEPTH));
    assign o_mid_pop = go;
    assign out_pop   = i_pop && !o_empty;

    // bytes left in the frame, zero once reached or passed
    assign left_diff = {1'b0, i_frame_bytes} - {1'b0, r_emitted};
    assign left      = left_diff[16] ? 16'd0 : left_diff[15:0];

    // saturating literal count sum
    assign sum_raw = {1'b0, r_len_sum} + 17'(i_mid.data_byte);
    assign sum_sat = sum_raw[16] ? 16'hFFFF : sum_raw[15:0];
    assign lit_dec = r_lit_left - 16'd1;

    assign cnt_w  = CMP_W'(i_mid.tbl_count);
    assign left_w = CMP_W'(left);

    // decode step
    always_comb begin
        n_phase    = r_phase;
        n_raw      = r_raw;
        n_len_sum  = r_len_sum;
        n_lit_left = r_lit_left;
        n_emitted  = r_emitted;
        res_valid  = 1'b0;
        res        = '0;
        if (go) begin
            case (i_mid.op)
                OP_FRAME: begin
                    n_raw      = ({1'b0, i_mid.dict_number} >= {1'b0, i_dict_count})
                                 || ({1'b0, i_mid.dict_number} >= 4'(TABLES));
                    n_emitted  = '0;
                    n_len_sum  = '0;
                    n_lit_left = '0;
                    n_phase    = PH_COUNT;
                end
                OP_DATA: begin
                    if (r_phase == PH_IDLE) begin
                        // bytes outside a frame are dropped
                    end else if (r_raw) begin
                        if (left == 16'd0) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_emitted          = r_emitted + 16'd1;
                            res_valid          = 1'b1;
                            res.run_value      = i_mid.data_byte;
                            res.repeat_count   = 16'd1;
                            if (left == 16'd1) begin
                                n_phase        = PH_IDLE;
                                res.frame_done = 1'b1;
                            end
                        end
                    end else begin
                        unique case (r_phase)
                            PH_COUNT: begin
                                if (i_mid.data_byte == LEN_ESCAPE) begin
                                    n_len_sum = sum_sat;
                                end else begin
                                    n_lit_left = sum_sat;
                                    n_len_sum  = '0;
                                    if (sum_sat != 16'd0) begin
                                        n_phase = PH_LIT;
                                    end else if (left == 16'd0) begin
                                        n_phase = PH_IDLE;
                                    end else begin
                                        n_phase = PH_CODE;
                                    end
                                end
                            end
                            PH_LIT: begin
                                if (left == 16'd0) begin
                                    n_phase = PH_IDLE;
                                end else begin
                                    n_emitted        = r_emitted + 16'd1;
                                    n_lit_left       = lit_dec;
                                    res_valid        = 1'b1;
                                    res.run_value    = i_mid.data_byte;
                                    res.repeat_count = 16'd1;
                                    if (left == 16'd1) begin
                                        n_phase        = PH_IDLE;
                                        res.frame_done = 1'b1;
                                        res.overrun    = (lit_dec != 16'd0);
                                    end else if (lit_dec == 16'd0) begin
                                        n_phase = PH_CODE;
                                    end
                                end
                            end
                            PH_CODE: begin
                                if (left == 16'd0) begin
                                    n_phase = PH_IDLE;
                                end else if (cnt_w == '0) begin
                                    n_phase = PH_COUNT;
                                end else if (cnt_w >= left_w) begin
                                    // dictionary run clipped at frame end
                                    n_emitted        = i_frame_bytes;
                                    n_phase          = PH_IDLE;
                                    res_valid        = 1'b1;
                                    res.run_value    = i_mid.tbl_value;
                                    res.repeat_count = left;
                                    res.frame_done   = 1'b1;
                                    res.overrun      = (cnt_w > left_w);
                                end else begin
                                    n_emitted        = r_emitted + 16'(cnt_w);
                                    n_phase          = PH_COUNT;
                                    res_valid        = 1'b1;
                                    res.run_value    = i_mid.tbl_value;
                                    res.repeat_count = 16'(cnt_w);
                                end
                            end
                            PH_IDLE: begin
                                n_phase = PH_IDLE;
                            end
                            default: begin
                                n_phase = PH_IDLE;
                            end
                        endcase
                    end
                end
                default: begin
                    // dictionary writes were done in the front end
                end
            endcase
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_raw      <= 1'b0;
            r_len_sum  <= '0;
            r_lit_left <= '0;
            r_emitted  <= '0;
        end else begin
            r_phase    <= n_phase;
            r_raw      <= n_raw;
            r_len_sum  <= n_len_sum;
            r_lit_left <= n_lit_left;
            r_emitted  <= n_emitted;
        end
    end

    // result queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_wr  <= '0;
            r_out_rd  <= '0;
            r_out_cnt <= '0;
        end else begin
            r_out_cnt <= r_out_cnt + (OUT_AW+1)'(res_valid) - (OUT_AW+1)'(out_pop);
            if (res_valid) begin
                r_out_wr <= r_out_wr + OUT_AW'(1);
            end
            if (out_pop) begin
                r_out_rd <= r_out_rd + OUT_AW'(1);
            end
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_q[r_out_wr] <= res;
        end
    end

    assign o_empty = (r_out_cnt == '0);
    assign o_run   = r_out_q[r_out_rd];
endmodule

[sv/dictionary_run_length_decoder.sv]
// Dictionary run-length decoder: takes one item per clock while full is low (compressed byte,
// frame start or dictionary entry write) and returns runs of (value, repeat count). An item's
// run reaches the result queue after the read stage and the front-end queue and can be popped
// at the next edge; the decoder keeps one item per cycle as long as results are popped, set by
// the single decode step in the back end and one lookup per cycle on the read port of the
// 1024 x 24 dictionary memory. A four-entry queue parts the front end from the decoder and a
// two-entry queue holds results. The dictionary memory has no reset and needs no clearing pass:
// a code that selects an entry never written gives an undefined run. Registers: frame_bytes at
// byte address 0, dict_count at 4; change them only while no item is in flight.
module dictionary_run_length_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item side
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_data_byte,
    input  logic [2:0]  i_dict_number,
    input  logic [7:0]  i_entry_index,
    input  logic [15:0] i_entry_count,
    input  logic [7:0]  i_entry_value,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_run_value,
    output logic [15:0] o_repeat_count,
    output logic        o_frame_done,
    output logic        o_overrun,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import drld_pkg::*;

    logic [15:0] r_frame_bytes;
    logic [2:0]  r_dict_count;
    logic        cfg_wr;
    t_reg_idx    reg_idx;
    logic        mid_valid;
    logic        mid_pop;
    t_mid_item   mid;
    t_run        run;

    // register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bytes <= FRAME_BYTES_RST;
            r_dict_count  <= DICT_COUNT_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_FRAME_BYTES: r_frame_bytes <= pwdata[15:0];
                REG_DICT_COUNT:  r_dict_count  <= pwdata[2:0];
                default:         r_dict_count  <= r_dict_count;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            REG_FRAME_BYTES: prdata = {16'd0, r_frame_bytes};
            REG_DICT_COUNT:  prdata = {29'd0, r_dict_count};
            default:         prdata = '0;
        endcase
    end

    drld_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_op          (i_op),
        .i_data_byte   (i_data_byte),
        .i_dict_number (i_dict_number),
        .i_entry_index (i_entry_index),
        .i_entry_count (i_entry_count),
        .i_entry_value (i_entry_value),
        .o_mid_valid   (mid_valid),
        .o_mid         (mid),
        .i_mid_pop     (mid_pop)
    );

    drld_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_bytes (r_frame_bytes),
        .i_dict_count  (r_dict_count),
        .i_mid_valid   (mid_valid),
        .i_mid         (mid),
        .o_mid_pop     (mid_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_run         (run)
    );

    // result fields
    assign o_run_value    = run.run_value;
    assign o_repeat_count = run.repeat_count;
    assign o_frame_done   = run.frame_done;
    assign o_overrun      = run.overrun;
endmodule
